// ===== rtl/ppmf_pkg.sv =====
// Shared types, constants and lookup functions for the packed palette mask filter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package ppmf_pkg;

    // Geometry of the stores
    localparam int SECTIONS      = 16;
    localparam int STORAGE_WORDS = 2048;
    localparam int MASK_WORDS    = 4;
    localparam int LOCAL_BITS    = 12;

    localparam int WORD_W     = 64;
    localparam int CAND_W     = 32;
    localparam int POS_W      = 32;
    localparam int PAL_W      = 32;
    localparam int EBITS_W    = 6;
    localparam int SLEN_W     = 12;
    localparam int SIU_W      = 5;
    localparam int MWPS_W     = 3;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam int MAX_ELEM_BITS = 32;

    localparam int SEC_W      = $clog2(SECTIONS);
    localparam int SW_AW      = $clog2(STORAGE_WORDS);
    localparam int MW_AW      = $clog2(MASK_WORDS);
    localparam int ST_AW      = SEC_W + SW_AW;
    localparam int MK_AW      = SEC_W + MW_AW;
    localparam int SEC_FULL_W = CAND_W - LOCAL_BITS;
    localparam int BIT_SEL_W  = $clog2(WORD_W);

    // Divider: local index over elements per word (2..64)
    localparam int PW_W      = 7;
    localparam int REM_W     = 6;
    localparam int DIV_STEPS = LOCAL_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SECTIONS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WORDS      = 1'b1;

    typedef enum logic [1:0] {
        MODE_STORAGE = 2'd0,
        MODE_MASK    = 2'd1,
        MODE_DESC    = 2'd2,
        MODE_CAND    = 2'd3
    } ppmf_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIV,
        ST_STORE_WAIT,
        ST_MASK_RD,
        ST_MASK_WAIT,
        ST_DONE
    } ppmf_state_t;

    typedef struct packed {
        logic                  start;
        logic [LOCAL_BITS-1:0] dividend;
        logic [PW_W-1:0]       divisor;
    } ppmf_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [LOCAL_BITS-1:0] quotient;
        logic [REM_W-1:0]      remainder;
    } ppmf_div_stat_t;

    typedef struct packed {
        logic              st_we;
        logic [ST_AW-1:0]  st_waddr;
        logic              mk_we;
        logic [MK_AW-1:0]  mk_waddr;
        logic [WORD_W-1:0] wdata;
        logic              st_re;
        logic [ST_AW-1:0]  st_raddr;
        logic              mk_re;
        logic [MK_AW-1:0]  mk_raddr;
    } ppmf_mem_req_t;

    // Elements per 64-bit word for a legal element width (1..32)
    function automatic logic [PW_W-1:0] per_word(input logic [EBITS_W-1:0] bits);
        logic [PW_W-1:0] pw;
        case (bits) inside
            6'd1:            pw = 7'd64;
            6'd2:            pw = 7'd32;
            6'd3:            pw = 7'd21;
            6'd4:            pw = 7'd16;
            6'd5:            pw = 7'd12;
            6'd6:            pw = 7'd10;
            6'd7:            pw = 7'd9;
            6'd8:            pw = 7'd8;
            6'd9:            pw = 7'd7;
            6'd10:           pw = 7'd6;
            [6'd11:6'd12]:   pw = 7'd5;
            [6'd13:6'd16]:   pw = 7'd4;
            [6'd17:6'd21]:   pw = 7'd3;
            [6'd22:6'd32]:   pw = 7'd2;
            default:         pw = 7'd0;
        endcase
        return pw;
    endfunction

endpackage

// ===== rtl/ppmf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ppmf_pkg (widths, request/status structs).

module ppmf_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ppmf_pkg::ppmf_div_req_t  req,
    output ppmf_pkg::ppmf_div_stat_t stat
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [ppmf_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic [ppmf_pkg::LOCAL_BITS-1:0] quo_reg, quo_next;
    logic [ppmf_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [ppmf_pkg::PW_W-1:0]       dvs_reg, dvs_next;
    logic [ppmf_pkg::REM_W:0]        trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[ppmf_pkg::LOCAL_BITS-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so trial fits 7 bits
            if (trial >= dvs_reg)
            begin
                rem_next = ppmf_pkg::REM_W'(trial - dvs_reg);
                quo_next = {quo_reg[ppmf_pkg::LOCAL_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ppmf_pkg::REM_W-1:0];
                quo_next = {quo_reg[ppmf_pkg::LOCAL_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ppmf_pkg::STEP_W'(ppmf_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

// ===== rtl/ppmf_mem.sv =====
// Storage-word and mask-word memories, one write and one registered read port each.
// Depends on ppmf_pkg (geometry, memory request struct).

module ppmf_mem (
    input  logic                          clk,
    input  ppmf_pkg::ppmf_mem_req_t       req,
    output logic [ppmf_pkg::WORD_W-1:0]   st_rdata,
    output logic [ppmf_pkg::WORD_W-1:0]   mk_rdata
);

    logic [ppmf_pkg::WORD_W-1:0] store_mem [ppmf_pkg::SECTIONS*ppmf_pkg::STORAGE_WORDS];
    logic [ppmf_pkg::WORD_W-1:0] mask_mem  [ppmf_pkg::SECTIONS*ppmf_pkg::MASK_WORDS];
    logic [ppmf_pkg::WORD_W-1:0] st_rdata_reg;
    logic [ppmf_pkg::WORD_W-1:0] mk_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.st_we)
            store_mem[req.st_waddr] <= req.wdata;
        if (req.st_re)
            st_rdata_reg <= store_mem[req.st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.mk_we)
            mask_mem[req.mk_waddr] <= req.wdata;
        if (req.mk_re)
            mk_rdata_reg <= mask_mem[req.mk_raddr];
    end

    assign st_rdata = st_rdata_reg;
    assign mk_rdata = mk_rdata_reg;

endmodule

// ===== rtl/packed_palette_mask_filter_top.sv =====
// Top level of the packed palette mask filter: sequencer, descriptors, result register.
// Depends on ppmf_pkg, ppmf_div (shared divider) and ppmf_mem (storage and mask memories).

// Each section holds bit-packed palette indices in 64-bit storage words, a
// descriptor (bits per element, number of valid storage words) and a mask
// bitmap. A write transaction (storage word, mask word, descriptor) completes in
// the cycle it is accepted. A candidate transaction is looked up in several
// steps: descriptor check, division of the local index by elements-per-word in
// a shared 12-step bit-serial divider, storage word read, element extraction,
// mask word read and bit test. From the accept, a candidate passes LOOKUP, then
// DONE if its section is rejected; else DIV if the element width is in range,
// STORE_WAIT if the packed word lies inside the storage length, MASK_RD,
// MASK_WAIT unless the mask word is out of use, and DONE. DIV holds until the
// divider is done; the finish step also holds while the result register is
// full and stalled. in_stall is high while a candidate is in flight. A finished
// result sits in the output register, so the next transaction is taken while
// the result waits for the consumer. Configuration writes (cfg_write, cfg_index,
// cfg_data) are meant for idle periods only.

module packed_palette_mask_filter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [ppmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input transactions
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic [ppmf_pkg::SEC_W-1:0]        section,
    input  logic [ppmf_pkg::SW_AW-1:0]        word_index,
    input  logic [ppmf_pkg::WORD_W-1:0]       word_data,
    input  logic [ppmf_pkg::EBITS_W-1:0]      bits_per_elem,
    input  logic [ppmf_pkg::SLEN_W-1:0]       storage_length,
    input  logic [ppmf_pkg::CAND_W-1:0]       candidate,
    input  logic                              last,
    // result transactions
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ppmf_pkg::POS_W-1:0]        position,
    output logic                              accepted,
    output logic                              batch_end
);

    ppmf_pkg::ppmf_state_t state_reg, state_next;
    ppmf_pkg::ppmf_mode_t  mode_in;

    // configuration
    logic [ppmf_pkg::SIU_W-1:0]  siu_reg;
    logic [ppmf_pkg::MWPS_W-1:0] mwps_reg;

    // per-section descriptors, cleared by reset
    logic [ppmf_pkg::EBITS_W-1:0] width_reg  [ppmf_pkg::SECTIONS];
    logic [ppmf_pkg::SLEN_W-1:0]  length_reg [ppmf_pkg::SECTIONS];

    logic [ppmf_pkg::POS_W-1:0] pos_cnt_reg, pos_cnt_next;

    // candidate in flight
    logic [ppmf_pkg::CAND_W-1:0]  cand_reg, cand_next;
    logic [ppmf_pkg::POS_W-1:0]   cpos_reg, cpos_next;
    logic                         clast_reg, clast_next;
    logic [ppmf_pkg::SEC_W-1:0]   sec_reg, sec_next;
    logic [ppmf_pkg::EBITS_W-1:0] bits_reg, bits_next;
    logic [ppmf_pkg::SLEN_W-1:0]  slen_reg, slen_next;
    logic [ppmf_pkg::BIT_SEL_W-1:0] shift_reg, shift_next;
    logic [ppmf_pkg::PAL_W-1:0]   pal_reg, pal_next;
    logic                         acc_reg, acc_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [ppmf_pkg::POS_W-1:0] out_pos_reg, out_pos_next;
    logic                       out_acc_reg, out_acc_next;
    logic                       out_end_reg, out_end_next;

    logic in_acc;
    logic write_sec_ok;
    logic desc_we;

    // lookup-step values
    logic [ppmf_pkg::SEC_FULL_W-1:0]  sec_full;
    logic [ppmf_pkg::SEC_W-1:0]       sec_idx;
    logic [ppmf_pkg::LOCAL_BITS-1:0]  cand_local;
    logic [ppmf_pkg::EBITS_W-1:0]     lk_bits;
    logic [ppmf_pkg::SLEN_W-1:0]      lk_len;
    logic                             sec_ok;
    logic                             bits_ok;
    logic                             word_ok;
    logic [ppmf_pkg::SLEN_W-1:0]      shift_prod;
    logic [ppmf_pkg::WORD_W-1:0]      shifted;
    logic [ppmf_pkg::WORD_W-1:0]      emask;
    logic [ppmf_pkg::PAL_W-ppmf_pkg::BIT_SEL_W-1:0] mword;
    logic                             mword_ok;

    ppmf_pkg::ppmf_div_req_t  div_req;
    ppmf_pkg::ppmf_div_stat_t div_stat;
    ppmf_pkg::ppmf_mem_req_t  mem_req;
    logic [ppmf_pkg::WORD_W-1:0] st_rdata;
    logic [ppmf_pkg::WORD_W-1:0] mk_rdata;

    ppmf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    ppmf_mem u_mem (
        .clk      (clk),
        .req      (mem_req),
        .st_rdata (st_rdata),
        .mk_rdata (mk_rdata)
    );

    assign mode_in      = ppmf_pkg::ppmf_mode_t'(mode);
    assign in_stall     = (state_reg != ppmf_pkg::ST_IDLE);
    assign in_acc       = in_valid && !in_stall;
    assign write_sec_ok = int'(section) < ppmf_pkg::SECTIONS;
    assign desc_we      = in_acc && (mode_in == ppmf_pkg::MODE_DESC) && write_sec_ok;

    // candidate fields: upper bits pick the section, low bits the local index
    assign sec_full   = cand_reg[ppmf_pkg::CAND_W-1:ppmf_pkg::LOCAL_BITS];
    assign sec_idx    = sec_full[ppmf_pkg::SEC_W-1:0];
    assign cand_local = cand_reg[ppmf_pkg::LOCAL_BITS-1:0];
    assign lk_bits    = width_reg[sec_idx];
    assign lk_len     = length_reg[sec_idx];
    assign sec_ok     = (sec_full < ppmf_pkg::SEC_FULL_W'(siu_reg)) &&
                        (sec_full < ppmf_pkg::SEC_FULL_W'(ppmf_pkg::SECTIONS));
    assign bits_ok    = (lk_bits != '0) &&
                        (lk_bits <= ppmf_pkg::EBITS_W'(ppmf_pkg::MAX_ELEM_BITS));

    // packed word must lie inside the section's valid storage
    assign word_ok    = (div_stat.quotient < slen_reg) &&
                        (div_stat.quotient < ppmf_pkg::SLEN_W'(ppmf_pkg::STORAGE_WORDS));
    assign shift_prod = ppmf_pkg::SLEN_W'(div_stat.remainder) * ppmf_pkg::SLEN_W'(bits_reg);

    // element extraction from the registered storage word
    assign shifted = st_rdata >> shift_reg;
    assign emask   = (ppmf_pkg::WORD_W'(1) << bits_reg) - ppmf_pkg::WORD_W'(1);

    // mask word selection from the palette index
    assign mword    = pal_reg[ppmf_pkg::PAL_W-1:ppmf_pkg::BIT_SEL_W];
    assign mword_ok = (mword < (ppmf_pkg::PAL_W-ppmf_pkg::BIT_SEL_W)'(mwps_reg)) &&
                      (mword < (ppmf_pkg::PAL_W-ppmf_pkg::BIT_SEL_W)'(ppmf_pkg::MASK_WORDS));

    always_comb
    begin
        state_next     = state_reg;
        pos_cnt_next   = pos_cnt_reg;
        cand_next      = cand_reg;
        cpos_next      = cpos_reg;
        clast_next     = clast_reg;
        sec_next       = sec_reg;
        bits_next      = bits_reg;
        slen_next      = slen_reg;
        shift_next     = shift_reg;
        pal_next       = pal_reg;
        acc_next       = acc_reg;
        out_pos_next   = out_pos_reg;
        out_acc_next   = out_acc_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && out_stall;

        div_req.start    = 1'b0;
        div_req.dividend = cand_local;
        div_req.divisor  = ppmf_pkg::per_word(lk_bits);

        // write transactions go straight to the memories
        mem_req.wdata    = word_data;
        mem_req.st_waddr = {section, word_index};
        mem_req.mk_waddr = {section, word_index[ppmf_pkg::MW_AW-1:0]};
        mem_req.st_we    = in_acc && (mode_in == ppmf_pkg::MODE_STORAGE) && write_sec_ok &&
                           (int'(word_index) < ppmf_pkg::STORAGE_WORDS);
        mem_req.mk_we    = in_acc && (mode_in == ppmf_pkg::MODE_MASK) && write_sec_ok &&
                           (int'(word_index) < ppmf_pkg::MASK_WORDS);
        mem_req.st_re    = 1'b0;
        mem_req.st_raddr = {sec_reg, div_stat.quotient[ppmf_pkg::SW_AW-1:0]};
        mem_req.mk_re    = 1'b0;
        mem_req.mk_raddr = {sec_reg, mword[ppmf_pkg::MW_AW-1:0]};

        case (state_reg)
            ppmf_pkg::ST_IDLE:
            begin
                if (in_acc && (mode_in == ppmf_pkg::MODE_CAND))
                begin
                    cand_next    = candidate;
                    cpos_next    = pos_cnt_reg;
                    clast_next   = last;
                    pos_cnt_next = last ? '0 : pos_cnt_reg + 1'b1;
                    state_next   = ppmf_pkg::ST_LOOKUP;
                end
            end
            ppmf_pkg::ST_LOOKUP:
            begin
                sec_next  = sec_idx;
                bits_next = lk_bits;
                slen_next = lk_len;
                if (!sec_ok)
                begin
                    acc_next   = 1'b0;
                    state_next = ppmf_pkg::ST_DONE;
                end
                else if (!bits_ok)
                begin
                    // no storage: palette index 0
                    pal_next   = '0;
                    state_next = ppmf_pkg::ST_MASK_RD;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ppmf_pkg::ST_DIV;
                end
            end
            ppmf_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (word_ok)
                    begin
                        mem_req.st_re = 1'b1;
                        shift_next    = shift_prod[ppmf_pkg::BIT_SEL_W-1:0];
                        state_next    = ppmf_pkg::ST_STORE_WAIT;
                    end
                    else
                    begin
                        pal_next   = '0;
                        state_next = ppmf_pkg::ST_MASK_RD;
                    end
                end
            end
            ppmf_pkg::ST_STORE_WAIT:
            begin
                pal_next   = ppmf_pkg::PAL_W'(shifted & emask);
                state_next = ppmf_pkg::ST_MASK_RD;
            end
            ppmf_pkg::ST_MASK_RD:
            begin
                if (mword_ok)
                begin
                    mem_req.mk_re = 1'b1;
                    state_next    = ppmf_pkg::ST_MASK_WAIT;
                end
                else
                begin
                    acc_next   = 1'b0;
                    state_next = ppmf_pkg::ST_DONE;
                end
            end
            ppmf_pkg::ST_MASK_WAIT:
            begin
                acc_next   = mk_rdata[pal_reg[ppmf_pkg::BIT_SEL_W-1:0]];
                state_next = ppmf_pkg::ST_DONE;
            end
            ppmf_pkg::ST_DONE:
            begin
                // hand over once the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = cpos_reg;
                    out_acc_next   = acc_reg;
                    out_end_next   = clast_reg;
                    state_next     = ppmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppmf_pkg::ST_IDLE;
            pos_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_cnt_reg   <= pos_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg  <= '0;
            mwps_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ppmf_pkg::CFG_SECTIONS_IN_USE: siu_reg  <= cfg_data[ppmf_pkg::SIU_W-1:0];
                ppmf_pkg::CFG_MASK_WORDS:      mwps_reg <= cfg_data[ppmf_pkg::MWPS_W-1:0];
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppmf_pkg::SECTIONS; i++)
            begin
                width_reg[i]  <= '0;
                length_reg[i] <= '0;
            end
        end
        else if (desc_we)
        begin
            width_reg[section]  <= bits_per_elem;
            length_reg[section] <= storage_length;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg    <= cand_next;
        cpos_reg    <= cpos_next;
        clast_reg   <= clast_next;
        sec_reg     <= sec_next;
        bits_reg    <= bits_next;
        slen_reg    <= slen_next;
        shift_reg   <= shift_next;
        pal_reg     <= pal_next;
        acc_reg     <= acc_next;
        out_pos_reg <= out_pos_next;
        out_acc_reg <= out_acc_next;
        out_end_reg <= out_end_next;
    end

    assign out_valid = out_valid_reg;
    assign position  = out_pos_reg;
    assign accepted  = out_acc_reg;
    assign batch_end = out_end_reg;

    // divider results only arrive while the sequencer waits for them
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ppmf_pkg::ST_DIV))
        else $error("divider finished outside the divide step");

    // an accepted candidate always starts a lookup next cycle
    a_cand_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (mode_in == ppmf_pkg::MODE_CAND)) |=> (state_reg == ppmf_pkg::ST_LOOKUP))
        else $error("candidate transaction did not start a lookup");

    // batch position restarts after the last candidate
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (mode_in == ppmf_pkg::MODE_CAND) && last) |=> (pos_cnt_reg == '0))
        else $error("position counter did not restart after batch end");

    // storage reads only for sections that passed the range check
    a_store_rd_sec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.st_re |-> (ppmf_pkg::SIU_W'(sec_reg) < siu_reg))
        else $error("storage read for a section out of use");

endmodule
